// ===== rtl/core/chd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the compass heading block: widths, angle constants, stage flags
// and the arctangent table function. It depends on nothing else.
package chd_pkg;

  localparam int MAG_W        = 16;
  localparam int MAG_ABS_W    = 16;
  localparam int HEAD_W       = 9;
  localparam int CORDIC_STEPS = 24;
  localparam int ANGLE_FRAC   = 24;
  localparam int PRE_SHIFT    = 30;
  localparam int XY_W         = MAG_ABS_W + PRE_SHIFT + 3;
  localparam int Z_W          = ANGLE_FRAC + 9;
  localparam int T_W          = ANGLE_FRAC + 6;
  localparam int A_W          = ANGLE_FRAC + 7;
  localparam int ANG_W        = ANGLE_FRAC + 8;
  localparam int IP_W         = ANG_W - ANGLE_FRAC;

  localparam logic [T_W-1:0]   DEG45_Q   = T_W'(45) << ANGLE_FRAC;
  localparam logic [A_W-1:0]   DEG90_Q   = A_W'(90) << ANGLE_FRAC;
  localparam logic [ANG_W-1:0] DEG180_Q  = ANG_W'(180) << ANGLE_FRAC;
  localparam logic [HEAD_W-1:0] DEG360   = HEAD_W'(360);
  localparam logic [63:0]      DEG_PER_RAD_Q24 = 64'd961263669;

  typedef struct packed {
    logic zero_both;
    logic t_zero;
    logic t_diag;
    logic swapped;
    logic x_neg;
    logic y_neg;
  } chd_flags_t;

  // Entry i is atan(2^-i) in degrees with ANGLE_FRAC fraction bits, rounded
  // to nearest. It is built from the arctangent series at elaboration.
  function automatic logic [31:0] atan_entry(input int unsigned i);
    longint      r;
    longint      term;
    logic [63:0] q32;
    logic [63:0] prod;
    int unsigned e;
    r = 0;
    if (i == 0) begin
      return 32'(45) << ANGLE_FRAC;
    end
    for (int unsigned k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        term = longint'((64'd1 << (60 - e)) / 64'(2 * k + 1));
        r = (k % 2 == 1) ? r - term : r + term;
      end
    end
    if (r < 0) begin
      r = 0;
    end
    q32  = 64'(r) >> 28;
    prod = q32 * DEG_PER_RAD_Q24 + (64'd1 << 31);
    return prod[63:32];
  endfunction

endpackage

// ===== rtl/core/chd_prep.sv =====
`timescale 1ns / 1ps
// Input stage: magnitudes, octant fold and special-case flags.
// Depends on chd_pkg.
module chd_prep (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic signed [chd_pkg::MAG_W-1:0] mag_x,
  input  logic signed [chd_pkg::MAG_W-1:0] mag_y,
  output logic                             valid_r,
  output logic [chd_pkg::MAG_ABS_W-1:0]    big_r,
  output logic [chd_pkg::MAG_ABS_W-1:0]    small_r,
  output chd_pkg::chd_flags_t              flags_r
);

  logic [chd_pkg::MAG_ABS_W-1:0] ax;
  logic [chd_pkg::MAG_ABS_W-1:0] ay;
  logic [chd_pkg::MAG_ABS_W-1:0] big_nxt;
  logic [chd_pkg::MAG_ABS_W-1:0] small_nxt;
  chd_pkg::chd_flags_t           flags_nxt;

  always_comb begin
    ax = mag_x[chd_pkg::MAG_W-1] ? chd_pkg::MAG_ABS_W'(-mag_x) : chd_pkg::MAG_ABS_W'(mag_x);
    ay = mag_y[chd_pkg::MAG_W-1] ? chd_pkg::MAG_ABS_W'(-mag_y) : chd_pkg::MAG_ABS_W'(mag_y);
    flags_nxt.swapped   = ay > ax;
    big_nxt             = flags_nxt.swapped ? ay : ax;
    small_nxt           = flags_nxt.swapped ? ax : ay;
    flags_nxt.zero_both = (ax == '0) && (ay == '0);
    flags_nxt.t_zero    = small_nxt == '0;
    flags_nxt.t_diag    = small_nxt == big_nxt;
    flags_nxt.x_neg     = mag_x[chd_pkg::MAG_W-1];
    flags_nxt.y_neg     = mag_y[chd_pkg::MAG_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      big_r   <= big_nxt;
      small_r <= small_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

// ===== rtl/core/chd_cordic.sv =====
`timescale 1ns / 1ps
// Vectoring CORDIC, one micro-rotation per register stage.
// Depends on chd_pkg.
module chd_cordic (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic [chd_pkg::MAG_ABS_W-1:0]         big,
  input  logic [chd_pkg::MAG_ABS_W-1:0]         small_in,
  input  chd_pkg::chd_flags_t                   flags_in,
  output logic                                  valid_out,
  output logic signed [chd_pkg::Z_W-1:0]        z_out,
  output chd_pkg::chd_flags_t                   flags_out
);

  localparam int N = chd_pkg::CORDIC_STEPS;

  logic                           valid_r [N];
  logic signed [chd_pkg::XY_W-1:0] x_r    [N];
  logic signed [chd_pkg::XY_W-1:0] y_r    [N];
  logic signed [chd_pkg::Z_W-1:0]  z_r    [N];
  chd_pkg::chd_flags_t            flags_r [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam logic signed [chd_pkg::Z_W-1:0] ATAN_G =
      chd_pkg::Z_W'(chd_pkg::atan_entry(g));

    logic                            v_src;
    logic signed [chd_pkg::XY_W-1:0] x_src;
    logic signed [chd_pkg::XY_W-1:0] y_src;
    logic signed [chd_pkg::Z_W-1:0]  z_src;
    chd_pkg::chd_flags_t             f_src;
    logic signed [chd_pkg::XY_W-1:0] x_nxt;
    logic signed [chd_pkg::XY_W-1:0] y_nxt;
    logic signed [chd_pkg::Z_W-1:0]  z_nxt;

    if (g == 0) begin : g_first
      always_comb begin
        v_src = in_valid;
        x_src = chd_pkg::XY_W'(big) <<< chd_pkg::PRE_SHIFT;
        y_src = chd_pkg::XY_W'(small_in) <<< chd_pkg::PRE_SHIFT;
        z_src = '0;
        f_src = flags_in;
      end
    end else begin : g_rest
      always_comb begin
        v_src = valid_r[g-1];
        x_src = x_r[g-1];
        y_src = y_r[g-1];
        z_src = z_r[g-1];
        f_src = flags_r[g-1];
      end
    end

    always_comb begin
      if (!y_src[chd_pkg::XY_W-1]) begin
        x_nxt = x_src + (y_src >>> g);
        y_nxt = y_src - (x_src >>> g);
        z_nxt = z_src + ATAN_G;
      end else begin
        x_nxt = x_src - (y_src >>> g);
        y_nxt = y_src + (x_src >>> g);
        z_nxt = z_src - ATAN_G;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (adv) begin
        valid_r[g] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[g]     <= x_nxt;
        y_r[g]     <= y_nxt;
        z_r[g]     <= z_nxt;
        flags_r[g] <= f_src;
      end
    end
  end

  assign valid_out = valid_r[N-1];
  assign z_out     = z_r[N-1];
  assign flags_out = flags_r[N-1];

endmodule

// ===== rtl/core/chd_post.sv =====
`timescale 1ns / 1ps
// Output stages: clamp, octant unfold, truncation, wrap and output register.
// Depends on chd_pkg; also produces the pipeline advance enable.
module chd_post (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [chd_pkg::Z_W-1:0]    z,
  input  chd_pkg::chd_flags_t               flags,
  input  logic                              out_ready,
  output logic                              adv,
  output logic                              out_valid_r,
  output logic [chd_pkg::HEAD_W-1:0]        heading_r
);

  logic                          a_valid_r;
  logic [chd_pkg::A_W-1:0]       a_r;
  chd_pkg::chd_flags_t           a_flags_r;
  logic [chd_pkg::T_W-1:0]       t;
  logic [chd_pkg::A_W-1:0]       a_nxt;
  logic [chd_pkg::ANG_W-1:0]     ang;
  logic [chd_pkg::IP_W-1:0]      ip;
  logic [chd_pkg::HEAD_W-1:0]    heading_nxt;
  logic                          out_load;

  always_comb begin
    if (flags.t_zero) begin
      t = '0;
    end else if (flags.t_diag) begin
      t = chd_pkg::DEG45_Q;
    end else if (z[chd_pkg::Z_W-1]) begin
      t = '0;
    end else if (z > chd_pkg::Z_W'(chd_pkg::DEG45_Q)) begin
      t = chd_pkg::DEG45_Q;
    end else begin
      t = z[chd_pkg::T_W-1:0];
    end
    a_nxt = flags.swapped ? chd_pkg::DEG90_Q - chd_pkg::A_W'(t) : chd_pkg::A_W'(t);
  end

  always_comb begin
    ang = a_flags_r.x_neg ? chd_pkg::DEG180_Q - chd_pkg::ANG_W'(a_r)
                          : chd_pkg::ANG_W'(a_r);
    ip  = ang[chd_pkg::ANG_W-1:chd_pkg::ANGLE_FRAC];
    if (a_flags_r.zero_both) begin
      heading_nxt = '0;
    end else if (a_flags_r.y_neg && (ip != '0)) begin
      heading_nxt = chd_pkg::DEG360 - chd_pkg::HEAD_W'(ip);
    end else begin
      heading_nxt = chd_pkg::HEAD_W'(ip);
    end
  end

  assign out_load = !out_valid_r || out_ready;
  assign adv      = out_load || !a_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        a_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r       <= a_nxt;
      a_flags_r <= flags;
    end
    if (out_load) begin
      heading_r <= heading_nxt;
    end
  end

endmodule

// ===== rtl/core/compass_heading_degrees_top.sv =====
`timescale 1ns / 1ps
// Compass heading top level: stream ports around fold, CORDIC and unfold stages.
// Depends on chd_pkg, chd_prep, chd_cordic and chd_post.
//
// Each request carries one signed X/Y magnetometer pair and yields one heading
// in whole degrees, 0 to 359, being atan2(y, x) truncated toward zero and
// wrapped. One request is taken every clock cycle unless the pipeline holds;
// each passes one fold stage, 24 CORDIC micro-rotation stages and two unfold
// stages. All stages before the output register move as one; they hold only
// when the output register is full and not taken while the stage in front of
// it also holds a result, so empty slots are filled while the consumer stalls.
module compass_heading_degrees_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] mag_x, [31:16] mag_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [8:0] heading_deg, [15:9] zero
);

  logic                              adv;
  logic                              p_valid;
  logic [chd_pkg::MAG_ABS_W-1:0]     p_big;
  logic [chd_pkg::MAG_ABS_W-1:0]     p_small;
  chd_pkg::chd_flags_t               p_flags;
  logic                              c_valid;
  logic signed [chd_pkg::Z_W-1:0]    c_z;
  chd_pkg::chd_flags_t               c_flags;
  logic [chd_pkg::HEAD_W-1:0]        heading;

  assign in_tready = adv;

  chd_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .mag_x    (in_tdata[15:0]),
    .mag_y    (in_tdata[31:16]),
    .valid_r  (p_valid),
    .big_r    (p_big),
    .small_r  (p_small),
    .flags_r  (p_flags)
  );

  chd_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (p_valid),
    .big       (p_big),
    .small_in  (p_small),
    .flags_in  (p_flags),
    .valid_out (c_valid),
    .z_out     (c_z),
    .flags_out (c_flags)
  );

  chd_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (c_valid),
    .z           (c_z),
    .flags       (c_flags),
    .out_ready   (out_tready),
    .adv         (adv),
    .out_valid_r (out_tvalid),
    .heading_r   (heading)
  );

  assign out_tdata = {7'b0, heading};

endmodule

// ===== rtl/core/chd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the compass heading top level, attached by bind.
// Depends only on the top level's ports.
module chd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("Output valid or blocked input after reset.");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[8:0] < 9'd360) && (out_tdata[15:9] == 7'd0))
    else $error("Heading outside 0 to 359 or padding not zero.");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("Input stalled while the output side could move.");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or dropped.");

endmodule

bind compass_heading_degrees_top chd_checker u_chd_checker (.*);
